FILE: rtl/core/msmt_pkg.sv
package msmt_pkg;

    localparam int NUM_STREAMS = 4;
    localparam int STREAM_W    = 2;
    localparam int SID_W       = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int WORD_W      = 32;
    localparam int MT_LEN      = 624;
    localparam int MT_SHIFT    = 397;
    localparam int IDX_W       = $clog2(MT_LEN + 1);
    localparam int ADDR_W      = $clog2(NUM_STREAMS * MT_LEN);
    localparam int S_TDATA_W   = ((STREAM_W + 7) / 8) * 8;

    localparam logic [WORD_W-1:0] SEED_MULT   = 32'd69069;
    localparam logic [WORD_W-1:0] RESET_SEED  = 32'd4357;
    localparam logic [WORD_W-1:0] MT_MATRIX   = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] MT_HIGH     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MT_LOW      = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] MT_TEMPER_B = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] MT_TEMPER_C = 32'hefc6_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic seed_start;
        logic seed_step;
        logic seed_done;
        logic tw_prime;
        logic tw_read;
        logic tw_write;
        logic out_read;
        logic out_load;
    } msmt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad_stream;
        logic seeded;
        logic idx_full;
        logic cnt_last;
        logic out_free;
    } msmt_status_t;

    function automatic logic [WORD_W-1:0] mt_temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [WORD_W-1:0] mt_twist_word(
        input logic [WORD_W-1:0] cur,
        input logic [WORD_W-1:0] nxt,
        input logic [WORD_W-1:0] far
    );
        logic [WORD_W-1:0] y;
        y = (cur & MT_HIGH) | (nxt & MT_LOW);
        return far ^ (y >> 1) ^ (y[0] ? MT_MATRIX : '0);
    endfunction

endpackage

FILE: rtl/core/msmt_ctrl.sv
module msmt_ctrl
    import msmt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  msmt_status_t status,
    output msmt_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEED,
        ST_TW_PRIME,
        ST_TW_READ,
        ST_TW_WRITE,
        ST_OUT_READ,
        ST_OUT_DATA
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (status.bad_stream) begin
                    state_next = ST_OUT_DATA;
                end else if (!status.seeded) begin
                    cmd.seed_start = 1'b1;
                    state_next     = ST_SEED;
                end else if (status.idx_full) begin
                    state_next = ST_TW_PRIME;
                end else begin
                    state_next = ST_OUT_READ;
                end
            end
            ST_SEED: begin
                cmd.seed_step = 1'b1;
                if (status.cnt_last) begin
                    cmd.seed_done = 1'b1;
                    state_next    = ST_TW_PRIME;
                end
            end
            ST_TW_PRIME: begin
                cmd.tw_prime = 1'b1;
                state_next   = ST_TW_READ;
            end
            ST_TW_READ: begin
                cmd.tw_read = 1'b1;
                state_next  = ST_TW_WRITE;
            end
            ST_TW_WRITE: begin
                cmd.tw_write = 1'b1;
                state_next   = status.cnt_last ? ST_OUT_READ : ST_TW_READ;
            end
            ST_OUT_READ: begin
                cmd.out_read = 1'b1;
                state_next   = ST_OUT_DATA;
            end
            ST_OUT_DATA: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/msmt_dp.sv
module msmt_dp
    import msmt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [STREAM_W-1:0]  s_stream,
    input  logic                 cfg_valid,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [WORD_W-1:0]    m_value,
    input  msmt_cmd_t            cmd,
    output msmt_status_t         status
);

    logic [WORD_W-1:0]   mem [NUM_STREAMS * MT_LEN];

    logic [WORD_W-1:0]   base_seed_reg;
    logic [STREAM_W-1:0] stream_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [IDX_W-1:0]    cnt_reg;
    logic [WORD_W-1:0]   seed_word_reg;
    logic [WORD_W-1:0]   cur_reg;
    logic [WORD_W-1:0]   rd_a_reg;
    logic [WORD_W-1:0]   rd_b_reg;
    logic [IDX_W-1:0]    word_index_reg [NUM_STREAMS];
    logic                seeded_reg [NUM_STREAMS];
    logic                m_tvalid_reg;
    logic [WORD_W-1:0]   m_value_reg;

    logic [SID_W-1:0]    sid;
    logic                bad_stream;
    logic                cnt_last;
    logic [IDX_W-1:0]    idx_next1;
    logic [IDX_W-1:0]    idx_far;
    logic [IDX_W-1:0]    rd_a_idx;
    logic [ADDR_W-1:0]   rd_a_addr;
    logic [ADDR_W-1:0]   rd_b_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic                wr_en;
    logic                rd_a_en;
    logic [WORD_W-1:0]   seed_prod;
    logic                out_free;

    assign sid        = SID_W'(stream_reg);
    assign bad_stream = (32'(stream_reg) >= NUM_STREAMS);
    assign cnt_last   = (cnt_reg == IDX_W'(MT_LEN - 1));
    assign out_free   = !m_tvalid_reg || m_tready;

    // Neighbor indexes of the twist, taken modulo the state length.
    assign idx_next1 = cnt_last ? '0 : cnt_reg + 1'b1;
    assign idx_far   = (cnt_reg < IDX_W'(MT_LEN - MT_SHIFT))
                     ? cnt_reg + IDX_W'(MT_SHIFT)
                     : cnt_reg - IDX_W'(MT_LEN - MT_SHIFT);

    always_comb begin
        rd_a_idx = '0;
        if (cmd.tw_read) begin
            rd_a_idx = idx_next1;
        end else if (cmd.out_read) begin
            rd_a_idx = word_index_reg[sid];
        end
    end

    assign rd_a_en   = cmd.tw_prime || cmd.tw_read || cmd.out_read;
    assign rd_a_addr = base_reg + ADDR_W'(rd_a_idx);
    assign rd_b_addr = base_reg + ADDR_W'(idx_far);
    assign wr_addr   = base_reg + ADDR_W'(cnt_reg);
    assign wr_en     = cmd.seed_step || cmd.tw_write;
    assign wr_data   = cmd.seed_step ? seed_word_reg
                                     : mt_twist_word(cur_reg, rd_a_reg, rd_b_reg);
    assign seed_prod = seed_word_reg * SEED_MULT;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en) begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (cmd.tw_read) begin
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            stream_reg <= s_stream;
            base_reg   <= ADDR_W'(s_stream) * ADDR_W'(MT_LEN);
        end
        if (cmd.seed_start) begin
            seed_word_reg <= base_seed_reg + WORD_W'(stream_reg);
        end else if (cmd.seed_step) begin
            seed_word_reg <= seed_prod;
        end
        if (cmd.seed_start || cmd.tw_prime) begin
            cnt_reg <= '0;
        end else if (cmd.seed_step || cmd.tw_write) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        // The first twist step takes word 0 from the priming read.
        if (cmd.tw_read && (cnt_reg == '0)) begin
            cur_reg <= rd_a_reg;
        end else if (cmd.tw_write) begin
            cur_reg <= rd_a_reg;
        end
        if (cmd.out_load) begin
            m_value_reg <= bad_stream ? '0 : mt_temper(rd_a_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_seed_reg <= RESET_SEED;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < NUM_STREAMS; i++) begin
                word_index_reg[i] <= IDX_W'(MT_LEN);
                seeded_reg[i]     <= 1'b0;
            end
        end else begin
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                base_seed_reg <= cfg_data;
                for (int i = 0; i < NUM_STREAMS; i++) begin
                    seeded_reg[i] <= 1'b0;
                end
            end else if (cmd.seed_done) begin
                seeded_reg[sid] <= 1'b1;
            end
            if (cmd.tw_write && cnt_last) begin
                word_index_reg[sid] <= '0;
            end else if (cmd.out_read) begin
                word_index_reg[sid] <= word_index_reg[sid] + 1'b1;
            end
        end
    end

    assign status.bad_stream = bad_stream;
    assign status.seeded     = seeded_reg[sid];
    assign status.idx_full   = (word_index_reg[sid] >= IDX_W'(MT_LEN));
    assign status.cnt_last   = cnt_last;
    assign status.out_free   = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_value  = m_value_reg;

endmodule

FILE: rtl/core/multi_stream_mersenne_twister_core.sv
// Four independent MT19937 generators share one 2496-word state memory with
// one write port and two read ports. Each input item names a stream and
// yields that stream's next tempered 32-bit word. A draw from a stream that
// still has words left passes the stream status check, the memory read and
// the tempering register before its result is offered; the tempered word is
// loaded only once the previous result has been taken from the output.
// The first draw of a stream after reset or after a base_seed write first
// seeds its 624 words, one per cycle through the seed multiplier. Every
// 624th draw of a stream, counted from the draw that seeds it, also runs
// the twist: a priming read, then one read pair and one write per word. The
// block takes one item at a time; a finished word waits in the output
// register while the next item is accepted. Writes of base_seed are taken
// at once and belong between items, while no item is in flight.
module multi_stream_mersenne_twister_core
    import msmt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,     // [1:0] stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [WORD_W-1:0]    m_tdata,     // [31:0] value
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [WORD_W-1:0]    cfg_data
);

    msmt_cmd_t    cmd;
    msmt_status_t status;
    logic         unused_pad;

    assign cfg_ready  = 1'b1;
    assign unused_pad = ^s_tdata[S_TDATA_W-1:STREAM_W];

    msmt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    msmt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_stream  (s_tdata[STREAM_W-1:0]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_value   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

FILE: bench/tb_multi_stream_mersenne_twister_core.sv
`timescale 1ns / 100ps

module tb_multi_stream_mersenne_twister_core;
    import msmt_pkg::*;

    localparam int          STREAMS     = NUM_STREAMS;
    localparam int          STATE_LEN   = 624;
    localparam int          FAR_OFFSET  = 397;
    localparam logic [31:0] TWIST_XOR   = 32'h9908_b0df;
    localparam logic [31:0] UPPER_BIT   = 32'h8000_0000;
    localparam logic [31:0] LOWER_BITS  = 32'h7fff_ffff;
    localparam logic [31:0] TEMPER_B    = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C    = 32'hefc6_0000;
    localparam logic [31:0] SEED_FACTOR = 32'd69069;
    localparam logic [31:0] SEED_AT_RST = 32'd4357;

    localparam logic [1:0] SEQ_ORDER [8] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd2, 2'd1, 2'd0};

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [WORD_W-1:0]    m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [WORD_W-1:0]    cfg_data;

    // Model of the generator bank.
    logic [31:0] mt_words [STREAMS][STATE_LEN];
    int          word_pos [STREAMS];
    bit          stream_seeded [STREAMS];
    logic [31:0] seed_reg;

    logic [31:0] expected_words [$];
    int          mismatches;
    int          tx_gap_max;
    int          rx_gap_max;

    multi_stream_mersenne_twister_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Next tempered word of one stream, seeding and twisting as needed.
    function automatic logic [31:0] draw_word(input int sid);
        logic [31:0] y;
        if (sid >= STREAMS) return '0;
        if (!stream_seeded[sid]) begin
            mt_words[sid][0] = seed_reg + 32'(sid);
            for (int i = 1; i < STATE_LEN; i++)
                mt_words[sid][i] = SEED_FACTOR * mt_words[sid][i-1];
            word_pos[sid]      = STATE_LEN;
            stream_seeded[sid] = 1'b1;
        end
        if (word_pos[sid] >= STATE_LEN) begin
            for (int k = 0; k < STATE_LEN; k++) begin
                y = (mt_words[sid][k] & UPPER_BIT)
                  | (mt_words[sid][(k + 1) % STATE_LEN] & LOWER_BITS);
                mt_words[sid][k] = mt_words[sid][(k + FAR_OFFSET) % STATE_LEN]
                                 ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'h0);
            end
            word_pos[sid] = 0;
        end
        y = mt_words[sid][word_pos[sid]];
        word_pos[sid]++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    task automatic send_draw(input logic [1:0] sid);
        int gap;
        gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {{(S_TDATA_W-2){1'b0}}, sid};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_words.push_back(draw_word(int'(sid)));
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    // The block is idle once every word has come back, since every item has a result.
    task automatic write_base_seed(input logic [31:0] value);
        drain_results();
        @(negedge aclk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        seed_reg = value;
        for (int i = 0; i < STREAMS; i++) stream_seeded[i] = 1'b0;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_reset_seed();
        tx_gap_max = 0;
        rx_gap_max = 0;
        foreach (SEQ_ORDER[i]) send_draw(SEQ_ORDER[i]);
        drain_results();
    endtask

    // A seed of one and the largest seed, the wrap of seed plus stream, and a zero seed.
    task automatic test_seed_extremes();
        tx_gap_max = 19;
        rx_gap_max = 19;
        write_base_seed(32'd1);
        for (int i = 0; i < STREAMS; i++) send_draw(2'(i));
        write_base_seed(32'hffff_ffff);
        send_draw(2'd1);
        send_draw(2'd0);
        send_draw(2'd3);
        send_draw(2'd1);
        write_base_seed(32'h0000_0000);
        send_draw(2'd2);
        send_draw(2'd0);
        send_draw(2'd0);
        drain_results();
    endtask

    // One stream is drawn past its whole state so it twists a second time.
    task automatic test_twist_rollover();
        logic [31:0] seed;
        logic [1:0]  hot;
        int          hot_draws;
        seed = $urandom();
        if (seed == 32'h0) seed = 32'd1;
        write_base_seed(seed);
        hot        = 2'($urandom_range(0, 3));
        hot_draws  = 0;
        while (hot_draws < 700) begin
            tx_gap_max = (hot_draws % 200 < 150) ? 19 : 0;
            rx_gap_max = (hot_draws % 160 < 100) ? 19 : 0;
            if ($urandom_range(0, 9) == 0) begin
                send_draw(2'($urandom_range(0, 3)));
            end else begin
                send_draw(hot);
                hot_draws++;
            end
        end
        drain_results();
    endtask

    task automatic test_random_phases();
        logic [31:0] seed;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_base_seed(32'd1);
                end
                5: begin
                    // Streams keep running from where the last phase left them.
                end
                7: begin
                    write_base_seed(32'hffff_ffff);
                end
                default: begin
                    seed = $urandom();
                    write_base_seed(seed == 32'h0 ? 32'd1 : seed);
                end
            endcase
            tx_gap_max = phase[0] ? 19 : 0;
            rx_gap_max = phase[1] ? 19 : 0;
            if (phase == 6) begin
                tx_gap_max = 19;
                rx_gap_max = 19;
            end
            for (int n = 0; n < 100; n++) send_draw(2'($urandom_range(0, 3)));
            drain_results();
        end
    endtask

    // Result receiver with random stalls.
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            gap = (rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0;
            @(negedge aclk);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h with nothing outstanding", m_tdata);
            end else if (m_tdata !== expected_words[0]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("value mismatch: expected %h, got %h", expected_words[0], m_tdata);
                void'(expected_words.pop_front());
            end else begin
                void'(expected_words.pop_front());
            end
        end
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        mismatches = 0;
        tx_gap_max = 0;
        rx_gap_max = 0;
        seed_reg   = SEED_AT_RST;
        for (int i = 0; i < STREAMS; i++) begin
            word_pos[i]      = STATE_LEN;
            stream_seeded[i] = 1'b0;
        end
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_seed();
        test_seed_extremes();
        test_twist_rollover();
        test_random_phases();

        drain_results();
        repeat (20) @(posedge aclk);
        if (expected_words.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
